FILE: rtl/core/irt_pkg.sv
// ----------------------------------------------------------------------------
// irt_pkg
// Shared types and codes for the inode reference table: entry layout, the
// write broadcast to the slot cells, opcodes and result status codes.
// ----------------------------------------------------------------------------
package irt_pkg;

  localparam int INODE_W   = 15;
  localparam int COUNT_W   = 16;
  localparam int SLOT_W    = 6;
  localparam int STATUS_W  = 3;
  // widest slot index for the largest supported table (256 slots)
  localparam int IDX_MAX_W = 8;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  typedef enum logic {
    OP_GET = 1'b0,
    OP_PUT = 1'b1
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_HIT       = 3'd0,
    ST_NEW       = 3'd1,
    ST_FULL      = 3'd2,
    ST_WRITEBACK = 3'd3,
    ST_HELD      = 3'd4,
    ST_PUT_FREE  = 3'd5,
    ST_SATURATED = 3'd6
  } status_t;

  typedef struct packed {
    logic [INODE_W-1:0] inode;
    logic [COUNT_W-1:0] count;
  } entry_t;

  // single-slot write, broadcast to every cell; the addressed cell takes it
  typedef struct packed {
    logic                 en;
    logic [IDX_MAX_W-1:0] idx;
    entry_t               data;
  } cell_wr_t;

endpackage

FILE: rtl/core/irt_req_if.sv
// ----------------------------------------------------------------------------
// irt_req_if
// Request channel: get by inode number or put by slot index.
// ----------------------------------------------------------------------------
interface irt_req_if;
  logic                         valid;
  logic                         ready;
  logic                         opcode;
  logic [irt_pkg::INODE_W-1:0]  inode_number;
  logic [irt_pkg::SLOT_W-1:0]   slot_index;

  modport source (output valid, output opcode, output inode_number, output slot_index,
                  input ready);
  modport sink   (input valid, input opcode, input inode_number, input slot_index,
                  output ready);
endinterface

FILE: rtl/core/irt_rsp_if.sv
// ----------------------------------------------------------------------------
// irt_rsp_if
// Response channel: status, slot, count after the request and inode number.
// ----------------------------------------------------------------------------
interface irt_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [irt_pkg::STATUS_W-1:0]  status;
  logic [irt_pkg::SLOT_W-1:0]    result_slot;
  logic [irt_pkg::COUNT_W-1:0]   reference_count;
  logic [irt_pkg::INODE_W-1:0]   result_inode;

  modport source (output valid, output status, output result_slot,
                  output reference_count, output result_inode, input ready);
  modport sink   (input valid, input status, input result_slot,
                  input reference_count, input result_inode, output ready);
endinterface

FILE: rtl/core/irt_cell.sv
// ----------------------------------------------------------------------------
// irt_cell
// One table slot in the rotating ring: holds inode number and count, takes
// its neighbor's entry on a shift, or the broadcast write when addressed.
// ----------------------------------------------------------------------------
module irt_cell #(
  parameter int CELL_INDEX = 0
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              shift_en,
  input  irt_pkg::cell_wr_t wr,
  input  irt_pkg::entry_t   shift_in,
  output irt_pkg::entry_t   entry
);

  localparam logic [irt_pkg::IDX_MAX_W-1:0] MY_IDX = irt_pkg::IDX_MAX_W'(CELL_INDEX);

  logic wr_hit;
  assign wr_hit = wr.en && (wr.idx == MY_IDX);

  // count: zero means free, so it is cleared by reset
  // inode number only matters while the count is nonzero, so it keeps its value
  always_ff @(posedge clk) begin
    if (rst) begin
      entry.count <= '0;
    end else if (wr_hit) begin
      entry <= wr.data;
    end else if (shift_en) begin
      entry <= shift_in;
    end
  end

endmodule

FILE: rtl/core/irt_ctrl.sv
// ----------------------------------------------------------------------------
// irt_ctrl
// Request sequencer: rotates the slot ring once past its head, records the
// matching slot, the lowest free slot or the named slot, then writes back
// the update and loads the response register.
// ----------------------------------------------------------------------------
module irt_ctrl #(
  parameter int TABLE_SLOTS = 64
) (
  input  logic              clk,
  input  logic              rst,
  irt_req_if.sink           req,
  irt_rsp_if.source         rsp,
  input  irt_pkg::entry_t   head,
  output logic              shift_en,
  output irt_pkg::cell_wr_t wr
);

  localparam int IDX_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SLOTS - 1);
  localparam int XW = irt_pkg::IDX_MAX_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_UPDATE
  } state_t;

  state_t state;

  // request copy
  irt_pkg::opcode_t              op;
  logic [irt_pkg::INODE_W-1:0]   ino;
  logic [irt_pkg::SLOT_W-1:0]    sidx;

  logic [IDX_W-1:0]              scan_idx;

  // scan findings
  logic                          hit;
  logic [IDX_W-1:0]              hit_idx;
  logic [irt_pkg::COUNT_W-1:0]   hit_cnt;
  logic                          free_found;
  logic [IDX_W-1:0]              free_idx;
  logic                          cap_valid;
  irt_pkg::entry_t               cap;

  // response register
  logic                          out_valid;
  irt_pkg::status_t              out_status;
  logic [irt_pkg::SLOT_W-1:0]    out_slot;
  logic [irt_pkg::COUNT_W-1:0]   out_count;
  logic [irt_pkg::INODE_W-1:0]   out_inode;

  // decision of the update cycle
  irt_pkg::status_t              res_status;
  logic [irt_pkg::SLOT_W-1:0]    res_slot;
  logic [irt_pkg::COUNT_W-1:0]   res_count;
  logic [irt_pkg::INODE_W-1:0]   res_inode;
  irt_pkg::cell_wr_t             upd;
  logic                          emit_ok;
  logic [irt_pkg::COUNT_W-1:0]   dec_cnt;
  logic [XW-1:0]                 hit_idx_x;
  logic [XW-1:0]                 free_idx_x;
  logic [XW-1:0]                 sidx_x;
  logic                          head_used;

  assign req.ready = (state == S_IDLE);
  assign shift_en  = (state == S_SCAN);
  assign emit_ok   = !out_valid || rsp.ready;

  assign rsp.valid           = out_valid;
  assign rsp.status          = out_status;
  assign rsp.result_slot     = out_slot;
  assign rsp.reference_count = out_count;
  assign rsp.result_inode    = out_inode;

  assign hit_idx_x  = XW'(hit_idx);
  assign free_idx_x = XW'(free_idx);
  assign sidx_x     = XW'(sidx);
  assign dec_cnt    = cap.count - irt_pkg::COUNT_W'(1);
  assign head_used  = (head.count != '0);

  always_comb begin
    upd        = '0;
    res_status = irt_pkg::ST_PUT_FREE;
    res_slot   = sidx;
    res_count  = '0;
    res_inode  = '0;
    if (op == irt_pkg::OP_GET) begin
      res_inode = ino;
      if (hit) begin
        res_slot = hit_idx_x[irt_pkg::SLOT_W-1:0];
        if (hit_cnt == irt_pkg::COUNT_MAX) begin
          res_status = irt_pkg::ST_SATURATED;
          res_count  = irt_pkg::COUNT_MAX;
        end else begin
          res_status      = irt_pkg::ST_HIT;
          res_count       = hit_cnt + irt_pkg::COUNT_W'(1);
          upd.en          = 1'b1;
          upd.idx         = hit_idx_x;
          upd.data.inode  = ino;
          upd.data.count  = res_count;
        end
      end else if (free_found) begin
        res_status     = irt_pkg::ST_NEW;
        res_slot       = free_idx_x[irt_pkg::SLOT_W-1:0];
        res_count      = irt_pkg::COUNT_W'(1);
        upd.en         = 1'b1;
        upd.idx        = free_idx_x;
        upd.data.inode = ino;
        upd.data.count = res_count;
      end else begin
        res_status = irt_pkg::ST_FULL;
        res_slot   = '0;
      end
    end else if (cap_valid && cap.count != '0) begin
      res_status     = (dec_cnt == '0) ? irt_pkg::ST_WRITEBACK : irt_pkg::ST_HELD;
      res_count      = dec_cnt;
      res_inode      = cap.inode;
      upd.en         = 1'b1;
      upd.idx        = sidx_x;
      upd.data.inode = cap.inode;
      upd.data.count = dec_cnt;
    end
    wr    = upd;
    wr.en = upd.en && (state == S_UPDATE) && emit_ok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (state == S_UPDATE && emit_ok) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            op         <= irt_pkg::opcode_t'(req.opcode);
            ino        <= req.inode_number;
            sidx       <= req.slot_index;
            scan_idx   <= '0;
            hit        <= 1'b0;
            free_found <= 1'b0;
            cap_valid  <= 1'b0;
            state      <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (op == irt_pkg::OP_GET) begin
            if (!hit && head_used && head.inode == ino) begin
              hit     <= 1'b1;
              hit_idx <= scan_idx;
              hit_cnt <= head.count;
            end
            if (!free_found && !head_used) begin
              free_found <= 1'b1;
              free_idx   <= scan_idx;
            end
          end else if (XW'(scan_idx) == sidx_x) begin
            cap_valid <= 1'b1;
            cap       <= head;
          end
          if (scan_idx == LAST_IDX) begin
            state <= S_UPDATE;
          end else begin
            scan_idx <= scan_idx + IDX_W'(1);
          end
        end
        S_UPDATE: begin
          if (emit_ok) begin
            out_status <= res_status;
            out_slot   <= res_slot;
            out_count  <= res_count;
            out_inode  <= res_inode;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: rtl/core/inode_reference_table.sv
// ----------------------------------------------------------------------------
// inode_reference_table
// Reference-counted table of open inodes: get by inode number (hit, claim
// of the lowest free slot, or table full) and put by slot (release with
// write-back when the count drops to zero).
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake      payload
//  -------  ---  -------------  ------------------------------------------------
//  req      in   valid / ready  opcode, inode_number, slot_index
//  rsp      out  valid / ready  status, result_slot, reference_count, result_inode
//
// a request runs through an accept in idle, a scan that rotates every slot
// past the head in turn, and an update that writes back and loads the response
// the slot ring is the limit: each slot is inspected once per request
// synchronous reset clears every count, so the table starts empty at once
// a waiting response does not block the next request; only the update cycle
// waits when the response register is still full
//
module inode_reference_table #(
  parameter int TABLE_SLOTS = 64
) (
  input  logic       clk,
  input  logic       rst,
  irt_req_if.sink    req,
  irt_rsp_if.source  rsp
);

  // ring of slot cells; cell 0 is the head seen by the sequencer.
  // each shift moves every entry one cell toward the head, so after
  // TABLE_SLOTS shifts every entry is back in its home cell
  irt_pkg::entry_t   ring [TABLE_SLOTS];
  logic              shift_en;
  irt_pkg::cell_wr_t wr;

  irt_ctrl #(
    .TABLE_SLOTS (TABLE_SLOTS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .rsp      (rsp),
    .head     (ring[0]),
    .shift_en (shift_en),
    .wr       (wr)
  );

  // writes land only in the update cycle, when the ring is at home,
  // so the broadcast index is the slot number itself
  for (genvar k = 0; k < TABLE_SLOTS; k++) begin : g_cell
    irt_cell #(
      .CELL_INDEX (k)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .shift_en (shift_en),
      .wr       (wr),
      .shift_in (ring[(k + 1) % TABLE_SLOTS]),
      .entry    (ring[k])
    );
  end

endmodule

FILE: rtl/core/irt_checker.sv
// ----------------------------------------------------------------------------
// irt_checker
// Port-level checks of the inode reference table, bound to the top level.
// ----------------------------------------------------------------------------
module irt_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          req_valid,
  input logic                          req_ready,
  input logic                          rsp_valid,
  input logic                          rsp_ready,
  input logic [irt_pkg::STATUS_W-1:0]  status,
  input logic [irt_pkg::SLOT_W-1:0]    result_slot,
  input logic [irt_pkg::COUNT_W-1:0]   reference_count,
  input logic [irt_pkg::INODE_W-1:0]   result_inode
);

  // response held while stalled
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(result_slot)
      && $stable(reference_count) && $stable(result_inode))
    else $error("response changed while stalled");

  // one request at a time: after an accept the table scans before the next
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request accepted during a scan");

  // a fresh claim always starts at one
  a_new_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status == irt_pkg::ST_NEW |-> reference_count == 16'd1)
    else $error("new slot without count one");

  // full, released and put-on-free results carry a zero count
  a_zero_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status == irt_pkg::ST_FULL || status == irt_pkg::ST_WRITEBACK
      || status == irt_pkg::ST_PUT_FREE) |-> reference_count == '0)
    else $error("nonzero count on a free slot result");

  // status code seven is never produced
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> status != 3'd7)
    else $error("undefined status code");

endmodule

bind inode_reference_table irt_checker u_irt_checker (
  .clk             (clk),
  .rst             (rst),
  .req_valid       (req.valid),
  .req_ready       (req.ready),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .status          (rsp.status),
  .result_slot     (rsp.result_slot),
  .reference_count (rsp.reference_count),
  .result_inode    (rsp.result_inode)
);
